// File: hdl/rfpcr_pkg.sv
`timescale 1ns / 1ps
package rfpcr_pkg;

   // field widths
   localparam int SP_W   = 10;
   localparam int PWR_W  = 8;
   localparam int CODE_W = 8;
   localparam int CSR_W  = 10;
   localparam int CSR_IDX_W = 2;

   // proportional step arithmetic
   localparam int ERR_W     = 11;   // signed set point minus forward power
   localparam int SQ_W      = 20;   // set point squared
   localparam int FRAC_W    = 22;   // signed numerator / denominator
   localparam int MAG_W     = 21;   // their magnitudes
   localparam int DIV_NUM_W = 29;   // drive code times numerator magnitude
   localparam int DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_DRIVE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REFLECT_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_RANGE_LIMIT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_RANGE_BAND  = 2'd3;

   // register reset values
   localparam logic [7:0] IDLE_DRIVE_RST      = 8'd50;
   localparam logic [7:0] REFLECT_LIMIT_RST   = 8'd200;
   localparam logic [9:0] LOW_RANGE_LIMIT_RST = 10'd100;
   localparam logic [7:0] LOW_RANGE_BAND_RST  = 8'd2;

   // loop modes
   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_COARSE = 2'd1;
   localparam logic [1:0] MODE_FINE   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_PREP,
      ST_MULT,
      ST_DIV,
      ST_SAT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;       // capture the input item
      logic eval;       // evaluate the loop, commit all but the proportional code
      logic prep;       // form numerator and denominator magnitudes
      logic mult;       // multiply and start the divider
      logic step;       // one divider iteration
      logic sat;        // commit the proportional code
      logic out_load;   // load the result register
   } cmd_type;

   typedef struct packed {
      logic need_div;   // item takes the proportional path
      logic div_last;   // divider on its last iteration
   } sts_type;

endpackage

// File: hdl/rfpcr_if.sv
`timescale 1ns / 1ps
interface rfpcr_req_if;
   import rfpcr_pkg::*;
   logic             valid;
   logic             ready;
   logic [SP_W-1:0]  set_point;
   logic [PWR_W-1:0] fwd_power;
   logic [PWR_W-1:0] refl_power;
   logic             rf_enable;
   logic             over_temp;

   modport source (output valid, set_point, fwd_power, refl_power, rf_enable,
                   over_temp, input ready);
   modport sink   (input valid, set_point, fwd_power, refl_power, rf_enable,
                   over_temp, output ready);
endinterface

interface rfpcr_rsp_if;
   import rfpcr_pkg::*;
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] drive_code;
   logic [PWR_W-1:0]  filtered_forward;
   logic signed [8:0] net_power;
   logic              reflect_fault;
   logic [1:0]        loop_mode;

   modport source (output valid, drive_code, filtered_forward, net_power, reflect_fault,
                   loop_mode, input ready);
   modport sink   (input valid, drive_code, filtered_forward, net_power, reflect_fault,
                   loop_mode, output ready);
endinterface

// File: hdl/rfpcr_div.sv
`timescale 1ns / 1ps
module rfpcr_div
   import rfpcr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 step,
   input  logic [CODE_W-1:0]    factor_a,
   input  logic [MAG_W-1:0]     factor_b,
   input  logic [MAG_W-1:0]     divisor,
   output logic [DIV_NUM_W-1:0] quotient,
   output logic                 last
);

   logic [MAG_W-1:0]     rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MAG_W:0]       trial;

   // restoring division, one quotient bit per cycle while step is high; the product lands in the
   // quotient register and is shifted out from the top
   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_NUM_W-1]} - {1'b0, divisor};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         quo_in = DIV_NUM_W'(factor_a) * DIV_NUM_W'(factor_b);
         cnt_in = '0;
      end else if (step) begin
         if (!trial[MAG_W]) begin
            rem_in = trial[MAG_W-1:0];
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[MAG_W-2:0], quo_ff[DIV_NUM_W-1]};
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign last     = (cnt_ff == DIV_LAST);

endmodule

// File: hdl/rfpcr_ctrl.sv
`timescale 1ns / 1ps
module rfpcr_ctrl
   import rfpcr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_load;

   // result register is free or being emptied this cycle
   assign can_load = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_EVAL;
         ST_EVAL:   state_in = sts.need_div ? ST_PREP : ST_FINISH;
         ST_PREP:   state_in = ST_MULT;
         ST_MULT:   state_in = ST_DIV;
         ST_DIV:    if (sts.div_last) state_in = ST_SAT;
         ST_SAT:    state_in = ST_FINISH;
         ST_FINISH: if (can_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EVAL:   cmd.eval = 1'b1;
         ST_PREP:   cmd.prep = 1'b1;
         ST_MULT:   cmd.mult = 1'b1;
         ST_DIV:    cmd.step = 1'b1;
         ST_SAT:    cmd.sat  = 1'b1;
         ST_FINISH: cmd.out_load = can_load;
         default:   cmd = '0;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while another is in flight");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before delivery");

   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result raised outside finish state");
`endif

endmodule

// File: hdl/rfpcr_dp.sv
`timescale 1ns / 1ps
module rfpcr_dp
   import rfpcr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic [SP_W-1:0]      set_point,
   input  logic [PWR_W-1:0]     fwd_power,
   input  logic [PWR_W-1:0]     refl_power,
   input  logic                 rf_enable,
   input  logic                 over_temp,
   output logic [CODE_W-1:0]    drive_code,
   output logic [PWR_W-1:0]     filtered_forward,
   output logic signed [8:0]    net_power,
   output logic                 reflect_fault,
   output logic [1:0]           loop_mode
);

   // configuration
   logic [7:0] idle_ff, idle_in;
   logic [7:0] rlim_ff, rlim_in;
   logic [9:0] lrl_ff, lrl_in;
   logic [7:0] lrb_ff, lrb_in;

   // captured item
   logic [SP_W-1:0]  s_ff, s_in;
   logic [PWR_W-1:0] fwd_ff, fwd_in;
   logic [PWR_W-1:0] refl_ff, refl_in;
   logic             en_ff, en_in;
   logic             hot_ff, hot_in;

   // loop state
   logic              regulating_ff, regulating_in;
   logic              kick_ff, kick_in;
   logic [CODE_W-1:0] drive_now_ff, drive_now_in;
   logic [CODE_W-1:0] drive_before_ff, drive_before_in;
   logic [PWR_W-1:0]  fwd_before_ff, fwd_before_in;
   logic              after_fine_ff, after_fine_in;
   logic              smooth_ff, smooth_in;

   // staged result fields and proportional operands
   logic [PWR_W-1:0]        f_ff, f_in;
   logic                    fault_ff, fault_in;
   logic [1:0]              mode_ff, mode_in;
   logic signed [ERR_W-1:0] e_ff, e_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic [MAG_W-1:0]        num_mag_ff, num_mag_in;
   logic [MAG_W-1:0]        den_mag_ff, den_mag_in;
   logic                    neg_ff, neg_in;
   logic                    den_zero_ff, den_zero_in;

   // result register
   logic [CODE_W-1:0] rsp_code_ff;
   logic [PWR_W-1:0]  rsp_fwd_ff;
   logic signed [8:0] rsp_net_ff;
   logic              rsp_fault_ff;
   logic [1:0]        rsp_mode_ff;

   // evaluation terms
   logic                    off;
   logic [PWR_W:0]          avg_sum;
   logic [PWR_W-1:0]        f;
   logic                    fault;
   logic signed [ERR_W-1:0] e;
   logic signed [ERR_W-1:0] e_abs;
   logic [SP_W-1:0]         ae;
   logic                    coarse;
   logic [12:0]             kick_x;
   logic [25:0]             kick_prod;
   logic [9:0]              kick_sum;
   logic [CODE_W-1:0]       kick_code;
   logic [21:0]             tol_lhs, tol_rhs;
   logic                    step_ok;
   logic [CODE_W-1:0]       db_eff;
   logic [CODE_W-1:0]       fine_code;

   // proportional terms
   logic signed [FRAC_W-1:0] e_x, num, den, num_abs, den_abs;
   logic [DIV_NUM_W-1:0]     quotient;
   logic                     div_last;
   logic [CODE_W-1:0]        prop_code;

   // configuration writes
   always_comb begin
      idle_in = idle_ff;
      rlim_in = rlim_ff;
      lrl_in  = lrl_ff;
      lrb_in  = lrb_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_IDLE_DRIVE:      idle_in = csr_wdata[7:0];
            CSR_REFLECT_LIMIT:   rlim_in = csr_wdata[7:0];
            CSR_LOW_RANGE_LIMIT: lrl_in  = csr_wdata[9:0];
            CSR_LOW_RANGE_BAND:  lrb_in  = csr_wdata[7:0];
            default:             idle_in = idle_ff;
         endcase
      end
   end

   // item capture
   always_comb begin
      s_in    = s_ff;
      fwd_in  = fwd_ff;
      refl_in = refl_ff;
      en_in   = en_ff;
      hot_in  = hot_ff;
      if (cmd.load) begin
         s_in    = set_point;
         fwd_in  = fwd_power;
         refl_in = refl_power;
         en_in   = rf_enable;
         hot_in  = over_temp;
      end
   end

   // filtering, fault and error
   always_comb begin
      off     = hot_ff || !en_ff || (s_ff == '0);
      avg_sum = {1'b0, fwd_before_ff} + {1'b0, fwd_ff};
      f       = (!off && after_fine_ff && smooth_ff) ? avg_sum[PWR_W:1] : fwd_ff;
      fault   = (refl_ff > rlim_ff) && ({2'b0, f} < s_ff);
      e       = $signed({1'b0, s_ff}) - $signed({3'b0, f});
      e_abs   = e[ERR_W-1] ? -e : e;
      ae      = e_abs[SP_W-1:0];
      coarse  = (({6'b0, ae} * 16'd50) > {6'b0, s_ff}) && !fault;
   end

   // overshoot kick: 6*(s+100)/25 + 74, division by reciprocal 5243 / 2^17
   always_comb begin
      kick_x    = 13'(({3'b0, s_ff} + 13'd100) * 13'd6);
      kick_prod = {13'b0, kick_x} * 26'd5243;
      kick_sum  = {1'b0, kick_prod[25:17]} + 10'd74;
      kick_code = (|kick_sum[9:8]) ? 8'hFF : kick_sum[7:0];
   end

   // fine step against the tolerance band
   always_comb begin
      tol_lhs = {12'b0, ae} * 22'd4000;
      tol_rhs = ({12'b0, s_ff} * 22'd11) + 22'd4600;
      if (s_ff <= lrl_ff) step_ok = ({2'b0, lrb_ff} < ae);
      else                step_ok = (tol_lhs >= tol_rhs);
      db_eff    = regulating_ff ? drive_before_ff : '0;
      fine_code = drive_now_ff;
      if (step_ok && !fault) begin
         if (!e[ERR_W-1] && (e != '0)) begin
            if (drive_now_ff != 8'hFF) fine_code = drive_now_ff + 1'b1;
         end else if (e[ERR_W-1]) begin
            if (drive_now_ff != 8'h00) fine_code = drive_now_ff - 1'b1;
         end
      end
   end

   // numerator 200e + s^2 and denominator 100e + s^2 as sign and magnitude
   always_comb begin
      e_x     = {{(FRAC_W-ERR_W){e_ff[ERR_W-1]}}, e_ff};
      num     = (e_x * 22'sd200) + $signed({2'b0, sq_ff});
      den     = (e_x * 22'sd100) + $signed({2'b0, sq_ff});
      num_abs = num[FRAC_W-1] ? -num : num;
      den_abs = den[FRAC_W-1] ? -den : den;
   end

   // saturate the truncated quotient
   always_comb begin
      if (den_zero_ff)              prop_code = drive_now_ff;
      else if (neg_ff)              prop_code = '0;
      else if (|quotient[DIV_NUM_W-1:CODE_W]) prop_code = 8'hFF;
      else                          prop_code = quotient[CODE_W-1:0];
   end

   // loop state and staging
   always_comb begin
      regulating_in   = regulating_ff;
      kick_in         = kick_ff;
      drive_now_in    = drive_now_ff;
      drive_before_in = drive_before_ff;
      fwd_before_in   = fwd_before_ff;
      after_fine_in   = after_fine_ff;
      smooth_in       = smooth_ff;
      f_in            = f_ff;
      fault_in        = fault_ff;
      mode_in         = mode_ff;
      e_in            = e_ff;
      sq_in           = sq_ff;
      num_mag_in      = num_mag_ff;
      den_mag_in      = den_mag_ff;
      neg_in          = neg_ff;
      den_zero_in     = den_zero_ff;

      if (cmd.eval) begin
         f_in     = f;
         fault_in = fault;
         e_in     = e;
         sq_in    = s_ff * s_ff;
         if (off) begin
            mode_in       = MODE_OFF;
            drive_now_in  = idle_ff;
            regulating_in = 1'b0;
            kick_in       = 1'b1;
            after_fine_in = 1'b0;
            smooth_in     = 1'b0;
         end else begin
            regulating_in = 1'b1;
            if (after_fine_ff) fwd_before_in = f;
            if (coarse) begin
               mode_in       = MODE_COARSE;
               after_fine_in = 1'b0;
               smooth_in     = 1'b0;
               if (kick_ff) begin
                  drive_now_in    = kick_code;
                  drive_before_in = kick_code;
                  kick_in         = 1'b0;
               end else begin
                  drive_before_in = db_eff;
               end
            end else begin
               mode_in         = MODE_FINE;
               drive_now_in    = fine_code;
               drive_before_in = fine_code;
               smooth_in       = (db_eff == fine_code);
               after_fine_in   = 1'b1;
            end
         end
      end

      if (cmd.prep) begin
         num_mag_in  = num_abs[MAG_W-1:0];
         den_mag_in  = den_abs[MAG_W-1:0];
         neg_in      = num[FRAC_W-1] ^ den[FRAC_W-1];
         den_zero_in = (den == '0);
      end

      if (cmd.sat) begin
         drive_now_in    = prop_code;
         drive_before_in = prop_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff         <= IDLE_DRIVE_RST;
         rlim_ff         <= REFLECT_LIMIT_RST;
         lrl_ff          <= LOW_RANGE_LIMIT_RST;
         lrb_ff          <= LOW_RANGE_BAND_RST;
         regulating_ff   <= 1'b0;
         kick_ff         <= 1'b1;
         drive_now_ff    <= '0;
         drive_before_ff <= '0;
         fwd_before_ff   <= '0;
         after_fine_ff   <= 1'b0;
         smooth_ff       <= 1'b0;
      end else begin
         idle_ff         <= idle_in;
         rlim_ff         <= rlim_in;
         lrl_ff          <= lrl_in;
         lrb_ff          <= lrb_in;
         regulating_ff   <= regulating_in;
         kick_ff         <= kick_in;
         drive_now_ff    <= drive_now_in;
         drive_before_ff <= drive_before_in;
         fwd_before_ff   <= fwd_before_in;
         after_fine_ff   <= after_fine_in;
         smooth_ff       <= smooth_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      fwd_ff      <= fwd_in;
      refl_ff     <= refl_in;
      en_ff       <= en_in;
      hot_ff      <= hot_in;
      f_ff        <= f_in;
      fault_ff    <= fault_in;
      mode_ff     <= mode_in;
      e_ff        <= e_in;
      sq_ff       <= sq_in;
      num_mag_ff  <= num_mag_in;
      den_mag_ff  <= den_mag_in;
      neg_ff      <= neg_in;
      den_zero_ff <= den_zero_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_code_ff  <= drive_now_ff;
         rsp_fwd_ff   <= f_ff;
         rsp_net_ff   <= $signed({1'b0, f_ff} - {1'b0, refl_ff});
         rsp_fault_ff <= fault_ff;
         rsp_mode_ff  <= mode_ff;
      end
   end

   rfpcr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.mult),
      .step     (cmd.step),
      .factor_a (drive_before_ff),
      .factor_b (num_mag_ff),
      .divisor  (den_mag_ff),
      .quotient (quotient),
      .last     (div_last)
   );

   assign sts.need_div = !off && coarse && !kick_ff;
   assign sts.div_last = div_last;

   assign drive_code       = rsp_code_ff;
   assign filtered_forward = rsp_fwd_ff;
   assign net_power        = rsp_net_ff;
   assign reflect_fault    = rsp_fault_ff;
   assign loop_mode        = rsp_mode_ff;

endmodule

// File: hdl/rf_power_coarse_fine_regulator.sv
`timescale 1ns / 1ps
// Sequence: an item taken in idle is evaluated, then goes straight to the result register on
//   the off and fine paths and on the kick; the proportional path first runs the serial divider.
// Flow: one item at a time; the next item is taken only after the previous result is loaded,
//   and loading waits while the receiver has not yet taken the result before it.
// Reset: synchronous, active high; clears the loop state and loads the register defaults.
module rf_power_coarse_fine_regulator
   import rfpcr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   rfpcr_req_if.sink            req_chan,
   rfpcr_rsp_if.source          rsp_chan,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   rfpcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rfpcr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .set_point        (req_chan.set_point),
      .fwd_power        (req_chan.fwd_power),
      .refl_power       (req_chan.refl_power),
      .rf_enable        (req_chan.rf_enable),
      .over_temp        (req_chan.over_temp),
      .drive_code       (rsp_chan.drive_code),
      .filtered_forward (rsp_chan.filtered_forward),
      .net_power        (rsp_chan.net_power),
      .reflect_fault    (rsp_chan.reflect_fault),
      .loop_mode        (rsp_chan.loop_mode)
   );

endmodule

// File: test/rf_power_coarse_fine_regulator_test.sv
`timescale 1ns / 1ps
module rf_power_coarse_fine_regulator_test;
   import rfpcr_pkg::*;

   localparam int QUIET_LIMIT  = 5000;  // cycles with no item moving on either side
   localparam int LONG_STALL   = 300;   // receiver hold-off that fills the block
   localparam int SETTLE_WAIT  = 40;    // longest latency plus margin
   localparam int PHASE_ITEMS  = 250;
   localparam int PHASE_COUNT  = 6;

   // one control tick as driven on the request channel
   typedef struct packed {
      logic [SP_W-1:0]  set_point;
      logic [PWR_W-1:0] fwd_power;
      logic [PWR_W-1:0] refl_power;
      logic             rf_enable;
      logic             over_temp;
   } tick_type;

   // one result as seen on the response channel
   typedef struct packed {
      logic [CODE_W-1:0] drive_code;
      logic [PWR_W-1:0]  filtered_forward;
      logic signed [8:0] net_power;
      logic              reflect_fault;
      logic [1:0]        loop_mode;
   } drive_result_type;

   typedef struct {
      tick_type         tick;
      bit               typed;
      drive_result_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   rfpcr_req_if req_bus ();
   rfpcr_rsp_if rsp_bus ();

   rf_power_coarse_fine_regulator DUT (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_bus),
      .rsp_chan     (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #1 clock = ~clock;

   // register mirror
   logic [7:0] idle_code_reg     = IDLE_DRIVE_RST;
   logic [7:0] reflect_limit_reg = REFLECT_LIMIT_RST;
   logic [9:0] low_limit_reg     = LOW_RANGE_LIMIT_RST;
   logic [7:0] band_reg          = LOW_RANGE_BAND_RST;

   // loop state mirror
   bit         loop_active = 1'b0;
   bit         kick_armed  = 1'b1;
   bit         fine_last   = 1'b0;
   bit         avg_next    = 1'b0;
   logic [7:0] code_now    = '0;
   logic [7:0] code_prev   = '0;
   logic [7:0] fwd_prev    = '0;

   drive_result_type expected_results[$];
   int  mismatch_count = 0;
   int  send_idle_pct  = 0;
   int  recv_idle_pct  = 0;
   bit  stall_request  = 1'b0;
   int  stall_left     = 0;
   int  quiet_cycles   = 0;
   int  burst_left     = 0;
   int  burst_sp       = 1;

   // directed ticks; expectations typed in only for the obvious ones
   row_type directed_rows [23] = '{
      '{'{10'd0,    8'd255, 8'd0,   1'b1, 1'b0}, 1'b1, '{8'd50,  8'd255, 9'd255, 1'b0, MODE_OFF}},
      '{'{10'd600,  8'd0,   8'd255, 1'b0, 1'b0}, 1'b1, '{8'd50,  8'd0,   9'h101, 1'b1, MODE_OFF}},
      '{'{10'd100,  8'd0,   8'd0,   1'b1, 1'b1}, 1'b1, '{8'd50,  8'd0,   9'd0,   1'b0, MODE_OFF}},
      '{'{10'd100,  8'd0,   8'd0,   1'b1, 1'b0}, 1'b1, '{8'd122, 8'd0,   9'd0,   1'b0,
                                                        MODE_COARSE}},
      '{'{10'd100,  8'd50,  8'd0,   1'b1, 1'b0}, 1'b0, '0},  // proportional
      '{'{10'd100,  8'd99,  8'd0,   1'b1, 1'b0}, 1'b0, '0},  // inside the fixed band
      '{'{10'd100,  8'd97,  8'd0,   1'b1, 1'b0}, 1'b0, '0},  // step up
      '{'{10'd100,  8'd100, 8'd0,   1'b1, 1'b0}, 1'b0, '0},  // after a changing fine tick
      '{'{10'd100,  8'd98,  8'd0,   1'b1, 1'b0}, 1'b0, '0},  // averaged reading
      '{'{10'd300,  8'd0,   8'd255, 1'b1, 1'b0}, 1'b0, '0},  // reflection fault holds
      '{'{10'd600,  8'd255, 8'd0,   1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd10,   8'd11,  8'd0,   1'b1, 1'b0}, 1'b0, '0},  // zero divisor
      '{'{10'd20,   8'd24,  8'd0,   1'b1, 1'b0}, 1'b0, '0},  // zero divisor again
      '{'{10'd100,  8'd175, 8'd0,   1'b1, 1'b0}, 1'b0, '0},  // negative ratio
      '{'{10'd250,  8'd254, 8'd0,   1'b1, 1'b0}, 1'b0, '0},  // step down at floor
      '{'{10'd0,    8'd0,   8'd0,   1'b1, 1'b0}, 1'b1, '{8'd50,  8'd0,   9'd0,   1'b0, MODE_OFF}},
      '{'{10'd1023, 8'd0,   8'd0,   1'b1, 1'b0}, 1'b1, '{8'd255, 8'd0,   9'd0,   1'b0,
                                                        MODE_COARSE}},
      '{'{10'd1023, 8'd255, 8'd0,   1'b1, 1'b0}, 1'b0, '0},  // ratio above full scale
      '{'{10'd250,  8'd246, 8'd0,   1'b1, 1'b0}, 1'b0, '0},  // step up at ceiling
      '{'{10'd200,  8'd198, 8'd0,   1'b1, 1'b0}, 1'b0, '0},
      '{'{10'd150,  8'd150, 8'd210, 1'b1, 1'b0}, 1'b0, '0},  // high reflection, no fault
      '{'{10'd1,    8'd0,   8'd0,   1'b0, 1'b1}, 1'b1, '{8'd50,  8'd0,   9'd0,   1'b0, MODE_OFF}},
      '{'{10'd601,  8'd255, 8'd201, 1'b1, 1'b0}, 1'b0, '0}   // fault on loop entry
   };

   function automatic logic [7:0] clamp_code(input longint v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
   endfunction

   // loop update for one tick: advances the mirrored state, returns the result
   function automatic drive_result_type regulate(input tick_type t);
      longint           sp, err, mag, den;
      logic [7:0]       f, code;
      logic [1:0]       mode;
      logic             fault, nudge;
      drive_result_type r;
      sp   = t.set_point;
      f    = t.fwd_power;
      mode = MODE_OFF;
      if (t.over_temp || !t.rf_enable || sp == 0) begin
         fault       = t.refl_power > reflect_limit_reg && longint'(f) < sp;
         code_now    = idle_code_reg;
         loop_active = 1'b0;
         kick_armed  = 1'b1;
         fine_last   = 1'b0;
         avg_next    = 1'b0;
      end else begin
         if (!loop_active) begin
            loop_active = 1'b1;
            code_prev   = '0;
         end
         // reading after a fine tick that held the code is averaged
         if (fine_last) begin
            if (avg_next) f = 8'((longint'(fwd_prev) + longint'(t.fwd_power)) / 2);
            fwd_prev = f;
         end
         fault = t.refl_power > reflect_limit_reg && longint'(f) < sp;
         err   = sp - longint'(f);
         mag   = (err < 0) ? -err : err;
         if (50 * mag > sp && !fault) begin
            mode = MODE_COARSE;
            if (kick_armed) begin
               code       = clamp_code((6 * (sp + 100)) / 25 + 74);
               kick_armed = 1'b0;
            end else begin
               den = 100 * err + sp * sp;
               if (den == 0) code = code_now;
               else code = clamp_code((longint'(code_prev) * (200 * err + sp * sp)) / den);
            end
            code_now  = code;
            code_prev = code;
            fine_last = 1'b0;
            avg_next  = 1'b0;
         end else begin
            mode = MODE_FINE;
            code = code_now;
            if (sp <= low_limit_reg) nudge = mag > band_reg;
            else nudge = 4000 * mag >= 11 * sp + 4600;
            if (nudge && !fault) begin
               if (err > 0) code = clamp_code(longint'(code_now) + 1);
               else if (err < 0) code = clamp_code(longint'(code_now) - 1);
            end
            code_now  = code;
            avg_next  = (code_prev == code);
            code_prev = code;
            fine_last = 1'b1;
         end
      end
      r.drive_code       = code_now;
      r.filtered_forward = f;
      r.net_power        = 9'(longint'(f) - longint'(t.refl_power));
      r.reflect_fault    = fault;
      r.loop_mode        = mode;
      return r;
   endfunction

   // random tick: mostly runs of regulation around one set point
   function automatic tick_type random_tick();
      tick_type t;
      int       pick, fw;
      pick = $urandom_range(99);
      if (burst_left == 0) begin
         burst_left = $urandom_range(40, 5);
         fw = $urandom_range(99);
         if (fw < 70) burst_sp = $urandom_range(255, 1);
         else if (fw < 90) burst_sp = $urandom_range(600, 256);
         else burst_sp = $urandom_range(1023, 601);
      end
      burst_left--;
      t.set_point  = SP_W'(burst_sp);
      t.rf_enable  = 1'b1;
      t.over_temp  = 1'b0;
      t.refl_power = ($urandom_range(99) < 15) ? 8'($urandom_range(255, 150))
                                               : 8'($urandom_range(60));
      fw = burst_sp + $urandom_range(12) - 6;
      if (fw < 0) fw = 0;
      if (fw > 255) fw = 255;
      t.fwd_power = 8'(fw);
      if (pick < 8) begin
         // noise over the whole field ranges
         t.set_point  = SP_W'($urandom);
         t.fwd_power  = 8'($urandom);
         t.refl_power = 8'($urandom);
         t.rf_enable  = 1'($urandom_range(1));
         t.over_temp  = 1'($urandom_range(1));
      end else if (pick < 14) begin
         // RF off in one of its three ways; rearms the kick
         case ($urandom_range(2))
            0: t.set_point = '0;
            1: t.rf_enable = 1'b0;
            default: t.over_temp = 1'b1;
         endcase
         burst_left = 0;
      end else if (pick < 24) begin
         t.fwd_power = 8'($urandom);
      end
      return t;
   endfunction

   task automatic send_item(input tick_type t, input drive_result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.set_point  = t.set_point;
      req_bus.fwd_power  = t.fwd_power;
      req_bus.refl_power = t.refl_power;
      req_bus.rf_enable  = t.rf_enable;
      req_bus.over_temp  = t.over_temp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_results.push_back(want);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = val;
      @(negedge clock);
      csr_write_en = 1'b0;
      case (idx)
         CSR_IDLE_DRIVE:      idle_code_reg     = val[7:0];
         CSR_REFLECT_LIMIT:   reflect_limit_reg = val[7:0];
         CSR_LOW_RANGE_LIMIT: low_limit_reg     = val[9:0];
         CSR_LOW_RANGE_BAND:  band_reg          = val[7:0];
         default:             ;
      endcase
   endtask

   task automatic apply_settings(input int idle_code, input int refl_limit,
                                 input int low_limit, input int band);
      wait_drained();
      write_reg(CSR_IDLE_DRIVE, CSR_W'(idle_code));
      write_reg(CSR_REFLECT_LIMIT, CSR_W'(refl_limit));
      write_reg(CSR_LOW_RANGE_LIMIT, CSR_W'(low_limit));
      write_reg(CSR_LOW_RANGE_BAND, CSR_W'(band));
   endtask

   task automatic check_field(input string name, input logic signed [9:0] want,
                              input logic signed [9:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // receiver readiness, with an occasional long hold-off
   always @(negedge clock) begin
      if (stall_request) begin
         stall_request = 1'b0;
         stall_left    = LONG_STALL;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready = 1'b0;
      end else begin
         rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $error("drive result arrived with nothing expected");
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("drive_code", want.drive_code, rsp_bus.drive_code);
            check_field("filtered_forward", want.filtered_forward, rsp_bus.filtered_forward);
            check_field("net_power", want.net_power, rsp_bus.net_power);
            check_field("reflect_fault", want.reflect_fault, rsp_bus.reflect_fault);
            check_field("loop_mode", want.loop_mode, rsp_bus.loop_mode);
         end
      end
   end

   // hang detection: no item moving for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      tick_type         t;
      drive_result_type predicted;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.set_point  = '0;
      req_bus.fwd_power  = '0;
      req_bus.refl_power = '0;
      req_bus.rf_enable  = 1'b0;
      req_bus.over_temp  = 1'b0;
      rsp_bus.ready      = 1'b0;
      csr_write_en       = 1'b0;
      csr_index          = CSR_IDLE_DRIVE;
      csr_wdata          = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // directed ticks at the reset register values
      send_idle_pct = 17;
      recv_idle_pct = 87;
      foreach (directed_rows[i]) begin
         predicted = regulate(directed_rows[i].tick);
         send_item(directed_rows[i].tick,
                   directed_rows[i].typed ? directed_rows[i].want : predicted);
      end

      // random phases, each with its own register setting; the idling pattern changes every two phases
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: apply_settings(0, 0, 0, 0);
            1: apply_settings(255, 255, 1023, 255);
            2: apply_settings($urandom_range(255), $urandom_range(255),
                              $urandom_range(600), $urandom_range(8));
            3: apply_settings($urandom_range(255), 100, 600, 0);
            4: apply_settings($urandom_range(255), $urandom_range(255),
                              $urandom_range(600), $urandom_range(255));
            default: apply_settings(IDLE_DRIVE_RST, REFLECT_LIMIT_RST,
                                    LOW_RANGE_LIMIT_RST, LOW_RANGE_BAND_RST);
         endcase
         if (phase < 2) begin
            send_idle_pct = 17;
            recv_idle_pct = 87;
         end else if (phase < 4) begin
            send_idle_pct = 87;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver hold-off while items keep coming
            if (phase == 2 && n == 40) stall_request = 1'b1;
            // sender pauses until the block has answered everything
            if (phase == 3 && n % 60 == 59) wait_drained();
            t = random_tick();
            send_item(t, regulate(t));
         end
      end

      wait_drained();
      repeat (SETTLE_WAIT) @(negedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
